### sv/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Default sizing
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the channels
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes; codes above OP_POP_BACK act as OP_NONE
    typedef enum logic [OP_W-1:0] {
        OP_NONE       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } t_op;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // Occupancy flags from the pointer unit
    typedef struct packed {
        logic empty;
        logic full;
        logic single;
    } t_ptr_flags;

endpackage

### sv/deq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the deque core: command in, response out.
// ----------------------------------------------------------------------------

// Command channel: one operation per transaction
interface deq_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [31:0] push_word;

    modport source (output valid, output operation, output push_word, input ready);
    modport sink   (input valid, input operation, input push_word, output ready);
endinterface

// Response channel: one result per command
interface deq_out_if #(
    parameter int OCC_W = 5
);
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [31:0]      front_word;
    logic [31:0]      back_word;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;

    modport source (
        output valid, output status, output front_word, output back_word,
        output occupancy, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input front_word, input back_word,
        input occupancy, input is_empty, output ready
    );
endinterface

### sv/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/deq_ptr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ptr
// Head, tail and count of the circular store, plus the slot addresses
// that each operation writes or reads.
// ----------------------------------------------------------------------------
module deq_ptr #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  deq_pkg::t_op               i_op,
    output deq_pkg::t_ptr_flags        o_flags,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic [$clog2(DEPTH)-1:0]   o_push_front_addr,
    output logic [$clog2(DEPTH)-1:0]   o_push_back_addr,
    output logic [$clog2(DEPTH)-1:0]   o_new_front_addr,
    output logic [$clog2(DEPTH)-1:0]   o_new_back_addr
);
    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // Circular step forward / backward
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;  // slot of the back word
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer update; the caller only steps legal operations
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_step) begin
            unique case (i_op)
                OP_PUSH_FRONT: begin
                    n_head  = idx_dec(r_head);
                    n_count = r_count + CNT_W'(1);
                end
                OP_PUSH_BACK: begin
                    n_tail  = idx_inc(r_tail);
                    n_count = r_count + CNT_W'(1);
                end
                OP_POP_FRONT: begin
                    n_head  = idx_inc(r_head);
                    n_count = r_count - CNT_W'(1);
                end
                OP_POP_BACK: begin
                    n_tail  = idx_dec(r_tail);
                    n_count = r_count - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Empty store: tail sits one slot behind head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= LAST_IDX;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_flags.empty  = (r_count == '0);
    assign o_flags.full   = (r_count == CNT_W'(DEPTH));
    assign o_flags.single = (r_count == CNT_W'(1));
    assign o_count        = r_count;

    assign o_push_front_addr = idx_dec(r_head);
    assign o_push_back_addr  = idx_inc(r_tail);
    assign o_new_front_addr  = idx_inc(r_head);
    assign o_new_back_addr   = idx_dec(r_tail);

endmodule

### sv/double_ended_queue_core.sv
// Timing: push, no-op, full and empty responses appear in the cycle after
//   the command transaction; a pop that leaves words passes the registered
//   read port of the slot RAM, then the response register, and takes no new
//   command meanwhile. Throughput: 1 command per cycle while o_rsp is ready.
// Reset: head, tail, count and handshake state clear at once; the slot RAM
//   is not cleared (no clearing pass), only written slots are ever read.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque in a circular RAM with cached front and back words.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_in_if.sink     i_cmd,
    deq_out_if.source  o_rsp
);
    import deq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state           r_state, n_state;
    t_op              w_op;
    t_ptr_flags       w_flags;
    logic [CNT_W-1:0] w_count;
    logic [IDX_W-1:0] w_push_front_addr, w_push_back_addr;
    logic [IDX_W-1:0] w_new_front_addr, w_new_back_addr;

    logic                  w_in_ready;
    logic                  w_step;
    logic                  w_load;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_addr;
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [DATA_WIDTH-1:0] w_word;
    logic [DATA_WIDTH-1:0] w_rd_data;

    // Cached end words and pending pop direction
    logic [DATA_WIDTH-1:0] r_front, n_front;
    logic [DATA_WIDTH-1:0] r_back, n_back;
    logic                  r_pop_front, n_pop_front;

    // Response register
    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    logic [31:0]      r_rsp_front, n_rsp_front;
    logic [31:0]      r_rsp_back, n_rsp_back;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic             r_rsp_empty, n_rsp_empty;

    assign w_op   = t_op'(i_cmd.operation);
    assign w_word = DATA_WIDTH'(i_cmd.push_word);

    deq_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_step),
        .i_op              (w_op),
        .o_flags           (w_flags),
        .o_count           (w_count),
        .o_push_front_addr (w_push_front_addr),
        .o_push_back_addr  (w_push_back_addr),
        .o_new_front_addr  (w_new_front_addr),
        .o_new_back_addr   (w_new_back_addr)
    );

    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_word),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: decode, RAM access and response build
    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_step      = 1'b0;
        w_load      = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_addr   = w_push_back_addr;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_new_back_addr;
        n_front     = r_front;
        n_back      = r_back;
        n_pop_front = r_pop_front;
        n_status    = r_status;
        n_occ       = r_occ;
        n_out_valid = r_out_valid && !o_rsp.ready;

        unique case (r_state)
            S_IDLE: begin
                w_in_ready = !r_out_valid || o_rsp.ready;
                if (w_in_ready && i_cmd.valid) begin
                    w_load   = 1'b1;
                    n_status = ST_OK;
                    n_occ    = w_count;
                    case (w_op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            if (w_flags.full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_step    = 1'b1;
                                w_wr_en   = 1'b1;
                                w_wr_addr = (w_op == OP_PUSH_FRONT) ? w_push_front_addr
                                                                    : w_push_back_addr;
                                n_occ     = w_count + CNT_W'(1);
                                if (w_op == OP_PUSH_FRONT || w_flags.empty) begin
                                    n_front = w_word;
                                end
                                if (w_op == OP_PUSH_BACK || w_flags.empty) begin
                                    n_back = w_word;
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (w_flags.empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                w_step = 1'b1;
                                n_occ  = w_count - CNT_W'(1);
                                // Words remain: fetch the new end word first
                                if (!w_flags.single) begin
                                    w_load      = 1'b0;
                                    w_rd_en     = 1'b1;
                                    w_rd_addr   = (w_op == OP_POP_FRONT) ? w_new_front_addr
                                                                         : w_new_back_addr;
                                    n_pop_front = (w_op == OP_POP_FRONT);
                                    n_state     = S_READ;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                w_load   = 1'b1;
                n_status = ST_OK;
                n_occ    = w_count;
                if (r_pop_front) begin
                    n_front = w_rd_data;
                end else begin
                    n_back = w_rd_data;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Response fields read zero when the deque is empty
        n_rsp_empty = (n_occ == '0);
        n_rsp_front = n_rsp_empty ? '0 : 32'(n_front);
        n_rsp_back  = n_rsp_empty ? '0 : 32'(n_back);
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_back      <= n_back;
        r_pop_front <= n_pop_front;
        if (w_load) begin
            r_status    <= n_status;
            r_rsp_front <= n_rsp_front;
            r_rsp_back  <= n_rsp_back;
            r_occ       <= n_occ;
            r_rsp_empty <= n_rsp_empty;
        end
    end

    assign i_cmd.ready      = w_in_ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.front_word = r_rsp_front;
    assign o_rsp.back_word  = r_rsp_back;
    assign o_rsp.occupancy  = r_occ;
    assign o_rsp.is_empty   = r_rsp_empty;

`ifndef SYNTHESIS
    // Count never runs past the store size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(DEPTH))
        else $error("deque count exceeds depth");

    // A RAM read always leads to the read-return state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |=> (r_state == S_READ))
        else $error("RAM read without read-return state");

    // The response slot is free while a pop waits on RAM data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("response register busy during RAM read");

    // A full response reports a full store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> (o_rsp.occupancy == CNT_W'(DEPTH)))
        else $error("full status with store not full");
`endif

endmodule
